@@ hw/rtl/energy_voice_activity_detector_defines.svh @@
// Assertion macros for the energy voice activity detector checker.
// Depends on clk_i and rst_ni being visible where the macros are used.
`ifndef ENERGY_VOICE_ACTIVITY_DETECTOR_DEFINES_SVH
`define ENERGY_VOICE_ACTIVITY_DETECTOR_DEFINES_SVH

// Same-cycle implication.
`define EVAD_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("evad assertion failed");

// Next-cycle implication.
`define EVAD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("evad assertion failed");

`endif

@@ hw/rtl/evad_pkg.sv @@
// Shared types and constants for the energy voice activity detector.
// No dependencies.
package evad_pkg;

  localparam int unsigned SampleW       = 16;
  localparam int unsigned RegW          = 16;
  localparam int unsigned SumW          = 26;
  localparam int unsigned MagW          = 17;
  localparam int unsigned CountW        = 16;
  localparam int unsigned KeptIdxW      = 10;
  localparam int unsigned CfgIdxW       = 2;
  localparam int unsigned MaxKeptFrames = 1024;

  localparam logic [RegW-1:0] ThresholdReset  = 16'd300;
  localparam logic [RegW-1:0] LoudStartReset  = 16'd0;
  localparam logic [RegW-1:0] QuietEndReset   = 16'd10;

  typedef enum logic [CfgIdxW-1:0] {
    REG_THRESHOLD   = 2'd0,
    REG_LOUD_START  = 2'd1,
    REG_QUIET_END   = 2'd2
  } evad_reg_e;

  typedef enum logic [1:0] {
    ST_START   = 2'd0,
    ST_SILENCE = 2'd1,
    ST_VOICE   = 2'd2
  } evad_status_e;

  typedef struct packed {
    logic [RegW-1:0] loud_start;
    logic [RegW-1:0] quiet_end;
  } evad_cfg_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [1:0]          prior;
    logic                loud;
    logic                done;
    logic                kept;
    logic [KeptIdxW-1:0] index;
  } evad_result_t;

endpackage

@@ hw/rtl/evad_accum.sv @@
// Per-frame level and threshold accumulators with the loud decision.
// Depends on evad_pkg.
module evad_accum import evad_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               adv_i,
  input  logic [SampleW-1:0] sample_i,
  input  logic               frame_end_i,
  input  logic [RegW-1:0]    threshold_i,
  output logic               loud_o
);

  localparam logic [SumW-1:0] SumMax = '1;

  logic [SumW-1:0] level_q, level_d;
  logic [SumW-1:0] thr_q, thr_d;
  logic [MagW-1:0] mag;
  logic [SumW:0]   level_add, thr_add;
  logic [SumW-1:0] level_sat, thr_sat;

  assign mag       = sample_i[SampleW-1] ? (MagW'(0) - {1'b1, sample_i}) : {1'b0, sample_i};
  assign level_add = {1'b0, level_q} + (SumW+1)'(mag);
  assign thr_add   = {1'b0, thr_q} + (SumW+1)'(threshold_i);
  assign level_sat = level_add[SumW] ? SumMax : level_add[SumW-1:0];
  assign thr_sat   = thr_add[SumW] ? SumMax : thr_add[SumW-1:0];
  assign loud_o    = level_sat >= thr_sat;

  always_comb begin
    level_d = level_q;
    thr_d   = thr_q;
    if (adv_i) begin
      level_d = frame_end_i ? '0 : level_sat;
      thr_d   = frame_end_i ? '0 : thr_sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= '0;
      thr_q   <= '0;
    end else begin
      level_q <= level_d;
      thr_q   <= thr_d;
    end
  end

endmodule

@@ hw/rtl/evad_fsm.sv @@
// Start/silence/voice machine, its counters and frame keeping.
// Depends on evad_pkg.
module evad_fsm import evad_pkg::*; #(
  parameter int unsigned MAX_KEPT_FRAMES = MaxKeptFrames
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         step_i,
  input  logic         loud_i,
  input  evad_cfg_t    cfg_i,
  output evad_result_t result_o
);

  localparam int unsigned KeptW = $clog2(MAX_KEPT_FRAMES + 1);
  localparam logic [KeptW-1:0] KeptMax  = KeptW'(MAX_KEPT_FRAMES);
  localparam logic [KeptW-1:0] KeptLast = KeptW'(MAX_KEPT_FRAMES - 1);

  evad_status_e      state_q, state_d;
  logic [CountW-1:0] loud_q, loud_d, loud_inc;
  logic [CountW-1:0] quiet_q, quiet_d, quiet_inc;
  logic [KeptW-1:0]  kept_q, kept_d, kept_base;
  logic              keep;

  assign loud_inc  = (loud_q == '1) ? loud_q : loud_q + CountW'(1);
  assign quiet_inc = (quiet_q == '1) ? quiet_q : quiet_q + CountW'(1);

  // next state and counters
  always_comb begin
    state_d   = state_q;
    loud_d    = loud_q;
    quiet_d   = quiet_q;
    kept_base = kept_q;
    case (state_q)
      ST_START: begin
        loud_d  = '0;
        quiet_d = '0;
        if (loud_i) begin
          kept_base = '0;
          state_d   = ST_VOICE;
        end else begin
          state_d = ST_SILENCE;
        end
      end
      ST_SILENCE: begin
        if (loud_i) begin
          loud_d = loud_inc;
          if (loud_inc >= cfg_i.loud_start) begin
            kept_base = '0;
            state_d   = ST_VOICE;
          end
        end else begin
          loud_d = '0;
        end
      end
      ST_VOICE: begin
        if (!loud_i) begin
          quiet_d = quiet_inc;
          if (quiet_inc >= cfg_i.quiet_end) state_d = ST_SILENCE;
        end else if (kept_q >= KeptLast) begin
          state_d = ST_SILENCE;
        end else begin
          quiet_d = '0;
        end
      end
      default: begin
        state_d = state_q;
      end
    endcase
  end

  // outputs
  always_comb begin
    keep            = (state_d == ST_VOICE) && (kept_base < KeptMax);
    kept_d          = keep ? kept_base + KeptW'(1) : kept_base;
    result_o.status = state_d;
    result_o.prior  = state_q;
    result_o.loud   = loud_i;
    result_o.done   = (state_q == ST_VOICE) && (state_d == ST_SILENCE);
    result_o.kept   = keep;
    result_o.index  = keep ? KeptIdxW'(kept_base) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_START;
      loud_q  <= '0;
      quiet_q <= '0;
      kept_q  <= '0;
    end else if (step_i) begin
      state_q <= state_d;
      loud_q  <= loud_d;
      quiet_q <= quiet_d;
      kept_q  <= kept_d;
    end
  end

endmodule

@@ hw/rtl/energy_voice_activity_detector.sv @@
// Energy voice activity detector top level: config registers, pipeline and handshake.
// Depends on evad_pkg, evad_accum, evad_fsm.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one signed 16-bit sample per
//   request plus a frame_end flag on the last sample of each frame.
//   Output channel (out_valid_o / out_stall_i) carries one result request per
//   frame: status, prior status, loud flag, utterance end, kept flag and index.
//   Config channel (cfg_valid_i / cfg_ready_o) writes threshold (index 0), loud
//   frames to start (1) and quiet frames to end (2); write only while idle.
//   Throughput: one sample per cycle, set by the single accumulate/decide stage,
//   unless a frame-end sample is held; its result is registered as it leaves.
//   Reset clears sums, counters and machine to the start state and loads the
//   register defaults (300, 0, 10); no result is pending after reset.
//   When out_stall_i holds a result, non-final samples keep flowing; a
//   frame-end sample waits in the input stage and in_stall_o rises.
module energy_voice_activity_detector import evad_pkg::*; #(
  parameter int unsigned MAX_KEPT_FRAMES = MaxKeptFrames
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [SampleW-1:0]  in_sample_i,
  input  logic                in_frame_end_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [1:0]          out_detector_status_o,
  output logic [1:0]          out_prior_status_o,
  output logic                out_frame_loud_o,
  output logic                out_utterance_done_o,
  output logic                out_frame_kept_o,
  output logic [KeptIdxW-1:0] out_kept_index_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [RegW-1:0]     cfg_data_i
);

  logic               s1_valid_q, s1_valid_d;
  logic [SampleW-1:0] s1_sample_q;
  logic               s1_fe_q;
  logic               out_valid_q, out_valid_d;
  evad_result_t       res_q, res;
  logic [RegW-1:0]    threshold_q;
  evad_cfg_t          cfg_q;
  logic               in_acc, out_free, s1_go, step, loud;

  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign s1_go       = s1_valid_q && (!s1_fe_q || out_free);
  assign step        = s1_go && s1_fe_q;
  assign in_stall_o  = s1_valid_q && !s1_go;
  assign in_acc      = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q      <= ThresholdReset;
      cfg_q.loud_start <= LoudStartReset;
      cfg_q.quiet_end  <= QuietEndReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_THRESHOLD:  threshold_q      <= cfg_data_i;
        REG_LOUD_START: cfg_q.loud_start <= cfg_data_i;
        REG_QUIET_END:  cfg_q.quiet_end  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_acc) s1_valid_d = 1'b1;
    else if (s1_go) s1_valid_d = 1'b0;
    out_valid_d = out_valid_q;
    if (step) out_valid_d = 1'b1;
    else if (!out_stall_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_sample_q <= in_sample_i;
      s1_fe_q     <= in_frame_end_i;
    end
    if (step) res_q <= res;
  end

  evad_accum u_accum (
    .clk_i,
    .rst_ni,
    .adv_i       (s1_go),
    .sample_i    (s1_sample_q),
    .frame_end_i (s1_fe_q),
    .threshold_i (threshold_q),
    .loud_o      (loud)
  );

  evad_fsm #(
    .MAX_KEPT_FRAMES (MAX_KEPT_FRAMES)
  ) u_fsm (
    .clk_i,
    .rst_ni,
    .step_i   (step),
    .loud_i   (loud),
    .cfg_i    (cfg_q),
    .result_o (res)
  );

  assign out_valid_o           = out_valid_q;
  assign out_detector_status_o = res_q.status;
  assign out_prior_status_o    = res_q.prior;
  assign out_frame_loud_o      = res_q.loud;
  assign out_utterance_done_o  = res_q.done;
  assign out_frame_kept_o      = res_q.kept;
  assign out_kept_index_o      = res_q.index;

endmodule

@@ hw/rtl/evad_checker.sv @@
// Port-level checker for the energy voice activity detector, bound to the top level.
// Depends on evad_pkg and energy_voice_activity_detector_defines.svh.
`include "energy_voice_activity_detector_defines.svh"

module evad_checker import evad_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic [SampleW-1:0]  in_sample_i,
  input logic                in_frame_end_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input logic [1:0]          out_detector_status_o,
  input logic [1:0]          out_prior_status_o,
  input logic                out_frame_loud_o,
  input logic                out_utterance_done_o,
  input logic                out_frame_kept_o,
  input logic [KeptIdxW-1:0] out_kept_index_o,
  input logic                cfg_valid_i,
  input logic                cfg_ready_o,
  input logic [CfgIdxW-1:0]  cfg_index_i,
  input logic [RegW-1:0]     cfg_data_i
);

  `EVAD_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o)
  `EVAD_ASSERT_NEXT(a_out_stable, out_valid_o && out_stall_i, $stable(out_detector_status_o) && $stable(out_kept_index_o) && $stable(out_frame_kept_o))
  `EVAD_ASSERT_IMPL(a_kept_voice, out_valid_o && out_frame_kept_o, out_detector_status_o == ST_VOICE)
  `EVAD_ASSERT_IMPL(a_done_edge, out_valid_o && out_utterance_done_o, (out_prior_status_o == ST_VOICE) && (out_detector_status_o == ST_SILENCE))

endmodule

bind energy_voice_activity_detector evad_checker u_checker (.*);
